[src/g2pf_pkg.sv]
// Package for the G2 packet frame parser: types, codes and constants.
`timescale 1ns / 1ps

package g2pf_pkg;

  // Control byte fields
  localparam logic [7:0] CtrlLenMask  = 8'hC0;
  localparam logic [7:0] CtrlNameMask = 8'h38;
  localparam logic [7:0] CtrlBigEndMask = 8'h02;

  // Largest length field, in bytes
  localparam logic [1:0] LenFieldMaxBytes = 2'd3;

  // Packet size limit after reset (1 MiB)
  localparam int unsigned LimitWidth = 25;
  localparam logic [LimitWidth-1:0] MaxPacketSizeRst = 25'd1048576;

  localparam int unsigned RemWidth = 24;
  localparam logic [RemWidth-1:0] RemSat = 24'hFFFFFF;

  // Output bus widths
  localparam int unsigned OutDataWidth = 40;
  localparam int unsigned OutUserWidth = 2;

  // Parser phase
  typedef enum logic [1:0] {
    PH_CTRL = 2'd0,
    PH_LEN  = 2'd1,
    PH_BODY = 2'd2,
    PH_ERR  = 2'd3
  } g2pf_phase_e;

  // Role of a byte in the stream
  typedef enum logic [1:0] {
    ROLE_CTRL    = 2'd0,
    ROLE_LEN     = 2'd1,
    ROLE_BODY    = 2'd2,
    ROLE_DISCARD = 2'd3
  } g2pf_role_e;

  // One tagged output word
  typedef struct packed {
    logic [7:0]          byte_out;
    g2pf_role_e          byte_role;
    logic [RemWidth-1:0] bytes_remaining;
    logic                packet_end;
    logic                too_large;
  } g2pf_result_t;

endpackage

[src/g2pf_parse.sv]
// Framing state and per-byte tagging logic of the G2 packet frame parser.
`timescale 1ns / 1ps

module g2pf_parse import g2pf_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  logic [7:0]            byte_i,
  input  logic [LimitWidth-1:0] max_size_i,
  output g2pf_result_t          res_o
);

  g2pf_phase_e           phase_q, phase_d;
  logic [1:0]            lfs_q, lfs_d;
  logic [2:0]            name_q, name_d;
  logic                  be_q, be_d;
  logic [1:0]            seen_q, seen_d;
  logic [RemWidth-1:0]   accum_q, accum_d;
  logic [LimitWidth-1:0] rem_q, rem_d;

  // Header-finish inputs, chosen per phase
  logic [1:0]            fin_lfs;
  logic [2:0]            fin_name;
  logic [RemWidth-1:0]   fin_accum;
  logic [LimitWidth-1:0] fin_total;
  logic [LimitWidth-1:0] fin_rem;
  logic                  fin_err;
  logic [RemWidth-1:0]   fin_rem_sat;
  logic [1:0]            ctrl_lfs;
  logic [2:0]            ctrl_name;
  logic [RemWidth-1:0]   len_accum;
  logic [LimitWidth-1:0] body_rem;

  // Field size from a control byte, clamped to the maximum
  assign ctrl_lfs = ((byte_i & CtrlLenMask) >> 6) > 8'(LenFieldMaxBytes) ?
                    LenFieldMaxBytes : byte_i[7:6];
  assign ctrl_name = 3'((byte_i & CtrlNameMask) >> 3);

  // Payload length with this length byte folded in
  always_comb begin
    if (be_q) begin
      len_accum = {accum_q[15:0], byte_i};
    end else begin
      case (seen_q)
        2'd0:    len_accum = accum_q | {16'd0, byte_i};
        2'd1:    len_accum = accum_q | {8'd0, byte_i, 8'd0};
        2'd2:    len_accum = accum_q | {byte_i, 16'd0};
        default: len_accum = accum_q;
      endcase
    end
  end

  // Header fields as seen by the byte that completes the header
  assign fin_lfs   = (phase_q == PH_CTRL) ? ctrl_lfs : lfs_q;
  assign fin_name  = (phase_q == PH_CTRL) ? ctrl_name : name_q;
  assign fin_accum = (phase_q == PH_CTRL) ? '0 : len_accum;

  // Header complete: total size check and body count
  assign fin_total   = 25'(fin_accum) + 25'(fin_name) + 25'(fin_lfs) + 25'd1;
  assign fin_err     = fin_total >= max_size_i;
  assign fin_rem     = 25'(fin_accum) + 25'(fin_name);
  assign fin_rem_sat = fin_rem[LimitWidth-1] ? RemSat : fin_rem[RemWidth-1:0];

  assign body_rem = (rem_q != '0) ? rem_q - 25'd1 : rem_q;

  // Next state and tagged result
  always_comb begin
    phase_d   = phase_q;
    lfs_d     = lfs_q;
    name_d    = name_q;
    be_d      = be_q;
    seen_d    = seen_q;
    accum_d   = accum_q;
    rem_d     = rem_q;

    res_o                 = '0;
    res_o.byte_out        = byte_i;
    res_o.byte_role       = ROLE_CTRL;

    unique case (phase_q)
      PH_CTRL: begin
        lfs_d     = ctrl_lfs;
        name_d    = ctrl_name;
        be_d      = (byte_i & CtrlBigEndMask) != 8'd0;
        seen_d    = 2'd0;
        accum_d   = '0;
        rem_d     = '0;
        res_o.byte_role = ROLE_CTRL;
        if (ctrl_lfs == 2'd0) begin
          if (fin_err) begin
            phase_d = PH_ERR;
          end else begin
            rem_d = fin_rem;
            res_o.bytes_remaining = fin_rem_sat;
            if (fin_rem == '0) begin
              res_o.packet_end = 1'b1;
              phase_d = PH_CTRL;
            end else begin
              phase_d = PH_BODY;
            end
          end
        end else begin
          phase_d = PH_LEN;
          res_o.bytes_remaining = 24'(ctrl_lfs);
        end
      end
      PH_LEN: begin
        res_o.byte_role = ROLE_LEN;
        accum_d   = len_accum;
        seen_d    = seen_q + 2'd1;
        if (seen_d >= lfs_q) begin
          if (fin_err) begin
            phase_d = PH_ERR;
          end else begin
            rem_d = fin_rem;
            res_o.bytes_remaining = fin_rem_sat;
            if (fin_rem == '0) begin
              res_o.packet_end = 1'b1;
              phase_d = PH_CTRL;
            end else begin
              phase_d = PH_BODY;
            end
          end
        end else begin
          res_o.bytes_remaining = 24'(lfs_q - seen_d);
        end
      end
      PH_BODY: begin
        res_o.byte_role = ROLE_BODY;
        rem_d = body_rem;
        res_o.bytes_remaining = body_rem[LimitWidth-1] ? RemSat : body_rem[RemWidth-1:0];
        if (body_rem == '0) begin
          res_o.packet_end = 1'b1;
          phase_d = PH_CTRL;
        end
      end
      PH_ERR: begin
        res_o.byte_role = ROLE_DISCARD;
      end
      default: begin
        res_o.byte_role = ROLE_DISCARD;
      end
    endcase

    res_o.too_large = (phase_d == PH_ERR);
  end

  // State registers, updated once per accepted byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_CTRL;
      lfs_q   <= '0;
      name_q  <= '0;
      be_q    <= 1'b0;
      seen_q  <= '0;
      accum_q <= '0;
      rem_q   <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      lfs_q   <= lfs_d;
      name_q  <= name_d;
      be_q    <= be_d;
      seen_q  <= seen_d;
      accum_q <= accum_d;
      rem_q   <= rem_d;
    end
  end

  // Error is sticky until reset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_ERR |=> phase_q == PH_ERR)
    else $error("error phase left without reset");

  // A body is only entered with bytes still to come
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_BODY |-> rem_q != '0)
    else $error("body phase with zero remaining count");

  // Inside the length field, fewer bytes seen than its size
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_LEN |-> (seen_q < lfs_q))
    else $error("length field count overran field size");

endmodule

[src/g2pf_out_buf.sv]
// Two-entry output buffer: result register plus skid entry for the stream output.
`timescale 1ns / 1ps

module g2pf_out_buf import g2pf_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  g2pf_result_t push_data_i,
  output logic         ready_o,
  output logic         valid_o,
  input  logic         pop_ready_i,
  output g2pf_result_t data_o
);

  logic         out_valid_q;
  logic         skid_valid_q;
  g2pf_result_t out_q;
  g2pf_result_t skid_q;
  logic         pop;

  assign ready_o = !skid_valid_q;
  assign valid_o = out_valid_q;
  assign data_o  = out_q;
  assign pop     = out_valid_q && pop_ready_i;

  // Valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (pop) begin
      if (skid_valid_q) begin
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= push_i;
      end
    end else if (push_i) begin
      if (out_valid_q) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end
  end

  // Payload words
  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (push_i) begin
        out_q <= push_data_i;
      end
    end else if (push_i) begin
      if (out_valid_q) begin
        skid_q <= push_data_i;
      end else begin
        out_q <= push_data_i;
      end
    end
  end

  // Skid entry only holds a word behind a full result register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry valid with empty result register");

endmodule

[src/g2_packet_frame_parser.sv]
// A byte accepted at an edge is registered and offered from it unless older words wait.
// Throughput: one byte per cycle; s_axis_tready stays high while the skid entry is free.
// A stall on the master side costs nothing until both output words are full.
// Reset: parser waits for a control byte, error cleared, limit set to 1048576.
// The configuration channel takes a write in every cycle.
`timescale 1ns / 1ps

module g2_packet_frame_parser import g2pf_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // Input stream
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  input  logic [7:0]              s_axis_tdata,   // [7:0] byte_in
  // Output stream
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  output logic [OutDataWidth-1:0] m_axis_tdata,   // [7:0] byte_out, [31:8] bytes_remaining,
                                                  // [32] too_large, [39:33] zero
  output logic [OutUserWidth-1:0] m_axis_tuser,   // [1:0] byte_role
  output logic                    m_axis_tlast,   // packet_end
  // Configuration write
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [LimitWidth-1:0]   cfg_data_i      // packet size limit
);

  logic [LimitWidth-1:0] max_size_q;
  logic                  in_fire;
  g2pf_result_t          step_res;
  g2pf_result_t          out_res;

  assign cfg_ready_o = 1'b1;
  assign in_fire     = s_axis_tvalid && s_axis_tready;

  // Packet size limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_size_q <= MaxPacketSizeRst;
    end else if (cfg_valid_i) begin
      max_size_q <= cfg_data_i;
    end
  end

  g2pf_parse u_parse (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (in_fire),
    .byte_i     (s_axis_tdata),
    .max_size_i (max_size_q),
    .res_o      (step_res)
  );

  g2pf_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_fire),
    .push_data_i (step_res),
    .ready_o     (s_axis_tready),
    .valid_o     (m_axis_tvalid),
    .pop_ready_i (m_axis_tready),
    .data_o      (out_res)
  );

  // Pack the output word
  assign m_axis_tdata = {7'd0, out_res.too_large, out_res.bytes_remaining, out_res.byte_out};
  assign m_axis_tuser = out_res.byte_role;
  assign m_axis_tlast = out_res.packet_end;

endmodule

[tb/sv/g2_packet_frame_parser_test.sv]
// Self-checking testbench for the G2 packet frame parser: stream driver, monitor, byte predictor.
`timescale 1ns / 1ps

module g2_packet_frame_parser_test;
  import g2pf_pkg::*;

  localparam int ClkPeriod     = 12;
  localparam int ResetCycles   = 5;
  localparam int IdlePercent   = 9;
  localparam int RxHoldCycles  = 300;
  localparam int DrainCycles   = 8;
  localparam int TimeoutCycles = 2000000;
  localparam int NoiseBytes    = 30;

  // How the run is closed out; the sticky error allows only one of these per run
  localparam int EndLimitZero     = 0;
  localparam int EndLimitOne      = 1;
  localparam int EndExactLimit    = 2;
  localparam int EndHugeLength    = 3;
  localparam int EndWideRemainder = 4;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [7:0]              s_axis_tdata = '0;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [OutDataWidth-1:0] m_axis_tdata;
  logic [OutUserWidth-1:0] m_axis_tuser;
  logic                    m_axis_tlast;
  logic                    cfg_valid_i = 1'b0;
  logic                    cfg_ready_o;
  logic [LimitWidth-1:0]   cfg_data_i = '0;

  // Stream bytes waiting to be offered, and tagged words still owed by the block
  logic [7:0]   tx_bytes[$];
  g2pf_result_t expected_words[$];

  // Traffic shaping
  bit idle_on     = 1'b1;
  bit tx_pause    = 1'b0;
  bit tx_taken    = 1'b0;
  bit rx_hold     = 1'b0;
  bit rx_hold_req = 1'b0;

  int mismatches     = 0;
  int words_checked  = 0;
  int frames_queued  = 0;
  int bytes_queued   = 0;
  int limit_writes   = 0;

  // Predictor state
  g2pf_phase_e           prs_phase     = PH_CTRL;
  logic [1:0]            prs_len_size  = '0;
  logic [2:0]            prs_name_size = '0;
  logic                  prs_big_end   = 1'b0;
  logic [1:0]            prs_len_seen  = '0;
  logic [23:0]           prs_pay_len   = '0;
  logic [24:0]           prs_body_left = '0;
  logic [LimitWidth-1:0] prs_limit     = MaxPacketSizeRst;

  logic         tx_next_valid;
  logic [7:0]   tx_next_data;
  g2pf_result_t mon_want;

  g2_packet_frame_parser dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Remaining count as reported: clipped to 24 bits
  function automatic logic [RemWidth-1:0] clip_remaining(logic [24:0] v);
    return (v > {1'b0, RemSat}) ? RemSat : v[RemWidth-1:0];
  endfunction

  // Header complete: apply the size limit, then load the name/payload count
  function automatic g2pf_result_t close_header(g2pf_result_t r);
    logic [31:0] total;
    total = 32'd1 + 32'(prs_len_size) + 32'(prs_name_size) + 32'(prs_pay_len);
    if (total >= {7'd0, prs_limit}) begin
      prs_phase = PH_ERR;
      r.bytes_remaining = '0;
      r.too_large = 1'b1;
    end else begin
      prs_body_left = 25'(prs_name_size) + 25'(prs_pay_len);
      r.bytes_remaining = clip_remaining(prs_body_left);
      if (prs_body_left == '0) begin
        r.packet_end = 1'b1;
        prs_phase = PH_CTRL;
      end else begin
        prs_phase = PH_BODY;
      end
    end
    return r;
  endfunction

  // Tag one stream byte and advance the framing state
  function automatic g2pf_result_t parse_byte(logic [7:0] b);
    g2pf_result_t r;
    logic [7:0]   fld;
    r = '0;
    r.byte_out = b;
    r.byte_role = ROLE_CTRL;
    case (prs_phase)
      PH_CTRL: begin
        fld = (b & CtrlLenMask) >> 6;
        if (fld > 8'(LenFieldMaxBytes)) fld = 8'(LenFieldMaxBytes);
        prs_len_size = fld[1:0];
        fld = (b & CtrlNameMask) >> 3;
        prs_name_size = fld[2:0];
        prs_big_end = |(b & CtrlBigEndMask);
        prs_len_seen = '0;
        prs_pay_len = '0;
        prs_body_left = '0;
        if (prs_len_size == 2'd0) begin
          r = close_header(r);
        end else begin
          prs_phase = PH_LEN;
          r.bytes_remaining = 24'(prs_len_size);
        end
      end
      PH_LEN: begin
        r.byte_role = ROLE_LEN;
        if (prs_big_end) prs_pay_len = {prs_pay_len[15:0], b};
        else prs_pay_len = prs_pay_len | ({16'd0, b} << (8 * prs_len_seen));
        prs_len_seen = prs_len_seen + 2'd1;
        if (prs_len_seen >= prs_len_size) r = close_header(r);
        else r.bytes_remaining = 24'(prs_len_size - prs_len_seen);
      end
      PH_BODY: begin
        r.byte_role = ROLE_BODY;
        if (prs_body_left != '0) prs_body_left = prs_body_left - 25'd1;
        r.bytes_remaining = clip_remaining(prs_body_left);
        if (prs_body_left == '0) begin
          r.packet_end = 1'b1;
          prs_phase = PH_CTRL;
        end
      end
      default: begin
        r.byte_role = ROLE_DISCARD;
      end
    endcase
    if (prs_phase == PH_ERR) r.too_large = 1'b1;
    return r;
  endfunction

  function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Input side: take the accepted byte and predict its word
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      expected_words.push_back(parse_byte(s_axis_tdata));
      void'(tx_bytes.pop_front());
      tx_taken = 1'b1;
    end
  end

  // Input side: hold an unaccepted byte, otherwise offer the next one or idle
  always @(negedge clk_i) begin
    tx_next_valid = s_axis_tvalid && !tx_taken;
    tx_next_data = s_axis_tdata;
    if (!tx_next_valid && rst_ni && tx_bytes.size() != 0 && !tx_pause &&
        !(idle_on && $urandom_range(0, 99) < IdlePercent)) begin
      tx_next_valid = 1'b1;
      tx_next_data = tx_bytes[0];
    end
    tx_taken = 1'b0;
    s_axis_tvalid <= tx_next_valid;
    s_axis_tdata <= tx_next_data;
  end

  // Output side: ready with random gaps, or held off
  always @(negedge clk_i) begin
    m_axis_tready <= !rx_hold && !(idle_on && $urandom_range(0, 99) < IdlePercent);
  end

  // Output side: check every accepted word against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_words.size() == 0) begin
        $error("word with no prediction: tdata %0h tuser %0h tlast %0b",
               m_axis_tdata, m_axis_tuser, m_axis_tlast);
        mismatches++;
      end else begin
        mon_want = expected_words.pop_front();
        compare_field("byte_out", 32'(mon_want.byte_out), 32'(m_axis_tdata[7:0]));
        compare_field("byte_role", 32'(mon_want.byte_role), 32'(m_axis_tuser[1:0]));
        compare_field("bytes_remaining", 32'(mon_want.bytes_remaining),
                      32'(m_axis_tdata[31:8]));
        compare_field("packet_end", 32'(mon_want.packet_end), 32'(m_axis_tlast));
        compare_field("too_large", 32'(mon_want.too_large), 32'(m_axis_tdata[32]));
        words_checked++;
      end
    end
  end

  // Long receiver hold-off, counted here so the sender keeps pushing meanwhile
  initial begin
    wait (rx_hold_req);
    @(posedge clk_i);
    rx_hold = 1'b1;
    repeat (RxHoldCycles) @(posedge clk_i);
    rx_hold = 1'b0;
  end

  initial begin
    #(ClkPeriod * TimeoutCycles);
    $display("** g2_packet_frame_parser: FAILED **");
    $finish;
  end

  task automatic wait_drained();
    while (tx_bytes.size() != 0 || expected_words.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [LimitWidth-1:0] v);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    prs_limit = v;
    limit_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Queue one frame: control byte, length field in the chosen order, then body bytes
  task automatic push_frame(int unsigned lfs, int unsigned nm, bit be, int unsigned pay,
                            int unsigned body);
    logic [7:0]  ctl;
    logic [31:0] w;
    int unsigned sh;
    ctl = {lfs[1:0], nm[2:0], 3'b000};
    ctl[2] = 1'($urandom_range(0, 1));
    ctl[1] = be;
    ctl[0] = 1'($urandom_range(0, 1));
    tx_bytes.push_back(ctl);
    for (int i = 0; i < lfs; i++) begin
      sh = be ? (lfs - 1 - i) : i;
      w = pay >> (8 * sh);
      tx_bytes.push_back(w[7:0]);
    end
    repeat (body) tx_bytes.push_back(8'($urandom_range(0, 255)));
    bytes_queued += 1 + lfs + body;
    frames_queued++;
  endtask

  // Random well-formed packet whose total stays below the limit
  task automatic push_packet(int unsigned lim);
    int unsigned lfs, nm, pay, room, pick;
    lfs = $urandom_range(0, 3);
    nm = $urandom_range(0, 7);
    pick = $urandom_range(0, 9);
    if (pick < 7) pay = $urandom_range(0, 10);
    else if (pick < 9) pay = $urandom_range(0, 40);
    else pay = $urandom_range(0, 300);
    if (lfs == 0) pay = 0;
    else if (lfs == 1 && pay > 255) pay = 255;
    if (1 + lfs + nm >= lim) begin
      // header alone would trip the limit: fall back to a bare control byte
      lfs = 0;
      pay = 0;
      if (nm > lim - 2) nm = lim - 2;
    end else begin
      room = lim - 2 - lfs - nm;
      if (pay > room) begin
        pay = room;
      end else if (lfs > 0 && room <= 300 && (lfs > 1 || room <= 255) &&
                   $urandom_range(0, 7) == 0) begin
        // one byte short of the limit
        pay = room;
      end
    end
    push_frame(lfs, nm, 1'($urandom_range(0, 1)), pay, nm + pay);
  endtask

  task automatic fill_phase(int n);
    int target;
    target = bytes_queued + n;
    while (bytes_queued < target) push_packet(prs_limit);
  endtask

  initial begin : stimulus
    int          ending;
    int unsigned lim, lfs, nm;
    string       ending_name;

    // Directed: bare control byte, name only, empty body after a length byte,
    // widest header in big-endian order, then both byte orders on a two-byte length
    tx_bytes = '{8'h00,
                 8'h10, 8'hA5, 8'h5A,
                 8'h40, 8'h00,
                 8'hFF, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h00, 8'h81, 8'h7E, 8'h01, 8'h80, 8'hC3,
                 8'h82, 8'h00, 8'h02, 8'hAA, 8'h55,
                 8'h88, 8'h02, 8'h00, 8'h11, 8'h22, 8'h33};
    repeat (ResetCycles) @(negedge clk_i);
    rst_ni <= 1'b1;
    wait_drained();

    // Smallest legal limit: only one-byte packets fit
    write_limit(25'd2);
    fill_phase(30);
    wait_drained();

    write_limit(25'd16777216);
    fill_phase(100);
    wait_drained();

    // Long stretch with no idling on either side
    idle_on = 1'b0;
    write_limit(25'($urandom_range(20, 400)));
    fill_phase(100);
    wait_drained();
    idle_on = 1'b1;

    // Tight limit while the receiver holds off and the input backs up
    write_limit(25'($urandom_range(12, 60)));
    fill_phase(100);
    rx_hold_req = 1'b1;
    wait_drained();

    // Sender stops mid-stream until every word is out
    write_limit(MaxPacketSizeRst);
    fill_phase(100);
    while (tx_bytes.size() >= 50) @(posedge clk_i);
    tx_pause = 1'b1;
    while (expected_words.size() != 0) @(posedge clk_i);
    tx_pause = 1'b0;
    wait_drained();

    write_limit(25'($urandom_range(2, 16777216)));
    fill_phase(100);
    wait_drained();

    // Close out: the error is sticky, so it can only be raised once per run
    ending = $urandom_range(EndLimitZero, EndWideRemainder);
    case (ending)
      EndLimitZero: begin
        ending_name = "limit 0, error on the next header";
        write_limit(25'd0);
        tx_bytes.push_back(8'($urandom_range(0, 255)));
      end
      EndLimitOne: begin
        ending_name = "limit 1, error on the next header";
        write_limit(25'd1);
        tx_bytes.push_back(8'($urandom_range(0, 255)));
      end
      EndExactLimit: begin
        ending_name = "packet total exactly at the limit";
        lfs = $urandom_range(1, 3);
        nm = $urandom_range(0, 7);
        lim = (lfs == 1) ? $urandom_range(20, 250) : $urandom_range(20, 400);
        write_limit(25'(lim));
        push_frame(lfs, nm, 1'($urandom_range(0, 1)), lim - 1 - lfs - nm, 0);
      end
      EndHugeLength: begin
        ending_name = "largest length field at the top limit";
        write_limit(25'd16777216);
        push_frame(3, $urandom_range(0, 7), 1'($urandom_range(0, 1)),
                   32'hFFFFFF - $urandom_range(0, 3), 0);
      end
      default: begin
        ending_name = "limit above range, remainder clipped to 24 bits";
        write_limit(25'h1FFFFFF);
        push_frame(3, 7, 1'($urandom_range(0, 1)), 32'hFFFFFF - $urandom_range(0, 3), 40);
      end
    endcase
    // discarded bytes after the error
    if (ending != EndWideRemainder) begin
      repeat (NoiseBytes) tx_bytes.push_back(8'($urandom_range(0, 255)));
    end
    wait_drained();

    $display("Summary: %0d words checked from %0d framed packets, %0d limit writes.",
             words_checked, frames_queued, limit_writes);
    $display("Summary: run closed with %s.", ending_name);
    if (mismatches == 0) begin
      $display("** g2_packet_frame_parser: PASSED **");
    end else begin
      $display("** g2_packet_frame_parser: FAILED **");
    end
    $finish;
  end

endmodule
